// ----- sv/crcdf_pkg.sv -----
package crcdf_pkg;

  localparam int unsigned HdrCrcSpan = 28;
  localparam int unsigned HdrBytes   = 32;
  localparam int unsigned FifoDepth  = 4;
  localparam logic [31:0] CrcPoly    = 32'hEDB88320;
  localparam logic [31:0] CrcInit    = 32'hFFFFFFFF;

  // configuration register indexes
  localparam logic [2:0] CFG_MAGIC   = 3'd0;
  localparam logic [2:0] CFG_VERSION = 3'd1;
  localparam logic [2:0] CFG_TYPE_LO = 3'd2;
  localparam logic [2:0] CFG_TYPE_HI = 3'd3;
  localparam logic [2:0] CFG_MAX_LEN = 3'd4;

  typedef enum logic [1:0] {
    KIND_HEADER,
    KIND_PAYLOAD,
    KIND_STATUS
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK,
    ST_BAD_MAGIC,
    ST_BAD_VERSION,
    ST_BAD_TYPE,
    ST_BAD_HDR_CRC,
    ST_TOO_LARGE,
    ST_BAD_PAYLOAD_CRC
  } status_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  payload_byte;
    logic [15:0] msg_type;
    logic [15:0] flag_bits;
    logic [15:0] reserved_bits;
    logic [63:0] correlation_id;
    logic [31:0] payload_len;
    status_t     status;
    logic        last;
  } res_t;

  // results produced by one accepted item
  typedef struct packed {
    logic [1:0] count;
    res_t       first;
    res_t       second;
  } push_t;

  function automatic logic [31:0] crc_byte(input logic [31:0] acc, input logic [7:0] b);
    logic [31:0] c;
    c = acc ^ {24'd0, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CrcPoly) : (c >> 1);
    end
    return c;
  endfunction

  function automatic res_t blank_res(input kind_t kind);
    res_t r;
    r = '0;
    r.kind = kind;
    return r;
  endfunction

endpackage

// ----- sv/crc_checked_frame_deframer.sv -----
// A result is written into the result queue by the edge that accepts the byte that causes it.
// Throughput: one byte per cycle while each byte yields at most one result and the output
// does not stall; the last payload byte and an accepted header with empty payload yield two
// results. Input stalls while the 4-entry result queue has fewer than two free slots.
// Reset: parse state and queue pointers clear, CRC accumulators load their initial value,
// configuration registers load their defaults; the header byte store is not cleared.
module crc_checked_frame_deframer
  import crcdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload_byte,
  output logic [15:0] out_msg_type,
  output logic [15:0] out_flag_bits,
  output logic [15:0] out_reserved_bits,
  output logic [63:0] out_correlation_id,
  output logic [31:0] out_payload_len,
  output logic [2:0]  out_status,
  output logic        out_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0] magic_r, max_len_r;
  logic [15:0] version_r, type_lo_r, type_hi_r;
  logic        in_fire, room2, pop;
  push_t       push;
  res_t        head;

  assign cfg_ready = 1'b1;
  assign in_stall  = !room2;
  assign in_fire   = in_valid && room2;
  assign pop       = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      magic_r   <= 32'd0;
      version_r <= 16'd1;
      type_lo_r <= 16'd1;
      type_hi_r <= 16'd37;
      max_len_r <= 32'd1048576;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MAGIC:   magic_r   <= cfg_data;
        CFG_VERSION: version_r <= cfg_data[15:0];
        CFG_TYPE_LO: type_lo_r <= cfg_data[15:0];
        CFG_TYPE_HI: type_hi_r <= cfg_data[15:0];
        CFG_MAX_LEN: max_len_r <= cfg_data;
        default: ;
      endcase
    end
  end

  crcdf_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_fire     (in_fire),
    .in_byte     (in_byte),
    .magic_word  (magic_r),
    .version_req (version_r),
    .type_min    (type_lo_r),
    .type_max    (type_hi_r),
    .max_payload (max_len_r),
    .push        (push)
  );

  crcdf_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .pop       (pop),
    .room2     (room2),
    .not_empty (out_valid),
    .head      (head)
  );

  assign out_kind           = head.kind;
  assign out_payload_byte   = head.payload_byte;
  assign out_msg_type       = head.msg_type;
  assign out_flag_bits      = head.flag_bits;
  assign out_reserved_bits  = head.reserved_bits;
  assign out_correlation_id = head.correlation_id;
  assign out_payload_len    = head.payload_len;
  assign out_status         = head.status;
  assign out_last           = head.last;

endmodule

// ----- sv/crcdf_parser.sv -----
module crcdf_parser
  import crcdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_fire,
  input  logic [7:0]  in_byte,
  input  logic [31:0] magic_word,
  input  logic [15:0] version_req,
  input  logic [15:0] type_min,
  input  logic [15:0] type_max,
  input  logic [31:0] max_payload,
  output push_t       push
);

  logic [7:0]  hdr_r [HdrCrcSpan];
  logic [4:0]  idx_r, idx_nxt;
  logic        phase_r, phase_nxt;
  logic [31:0] hcrc_r, hcrc_nxt;
  logic [31:0] pcrc_r, pcrc_nxt;
  logic [31:0] scrc_r, scrc_nxt;
  logic [31:0] left_r, left_nxt;

  logic [31:0] f_magic, f_len, f_pcrc, f_corr_lo, f_corr_hi, hdr_crc_word, pcrc_upd, left_dec;
  logic [15:0] f_ver, f_type, f_flags, f_rsvd;
  status_t     st;
  logic        hdr_wr;

  assign f_magic   = {hdr_r[3], hdr_r[2], hdr_r[1], hdr_r[0]};
  assign f_ver     = {hdr_r[5], hdr_r[4]};
  assign f_type    = {hdr_r[7], hdr_r[6]};
  assign f_flags   = {hdr_r[9], hdr_r[8]};
  assign f_rsvd    = {hdr_r[11], hdr_r[10]};
  assign f_corr_lo = {hdr_r[15], hdr_r[14], hdr_r[13], hdr_r[12]};
  assign f_corr_hi = {hdr_r[19], hdr_r[18], hdr_r[17], hdr_r[16]};
  assign f_len     = {hdr_r[23], hdr_r[22], hdr_r[21], hdr_r[20]};
  assign f_pcrc    = {hdr_r[27], hdr_r[26], hdr_r[25], hdr_r[24]};

  assign hdr_crc_word = {in_byte, scrc_r[23:0]};
  assign pcrc_upd     = crc_byte(pcrc_r, in_byte);
  assign left_dec     = left_r - 32'd1;
  assign hdr_wr       = in_fire && !phase_r && (idx_r < 5'(HdrCrcSpan));

  always_comb begin
    if (f_magic != magic_word) begin
      st = ST_BAD_MAGIC;
    end else if (f_ver != version_req) begin
      st = ST_BAD_VERSION;
    end else if ((f_type < type_min) || (f_type > type_max)) begin
      st = ST_BAD_TYPE;
    end else if (~hcrc_r != hdr_crc_word) begin
      st = ST_BAD_HDR_CRC;
    end else if (f_len > max_payload) begin
      st = ST_TOO_LARGE;
    end else begin
      st = ST_OK;
    end
  end

  always_comb begin
    idx_nxt     = idx_r;
    phase_nxt   = phase_r;
    hcrc_nxt    = hcrc_r;
    pcrc_nxt    = pcrc_r;
    scrc_nxt    = scrc_r;
    left_nxt    = left_r;
    push        = '0;
    push.first  = blank_res(KIND_STATUS);
    push.second = blank_res(KIND_STATUS);
    if (in_fire) begin
      if (phase_r) begin
        pcrc_nxt                  = pcrc_upd;
        left_nxt                  = left_dec;
        push.first                = blank_res(KIND_PAYLOAD);
        push.first.payload_byte   = in_byte;
        if (left_dec != 32'd0) begin
          push.count      = 2'd1;
          push.first.last = 1'b1;
        end else begin
          push.count         = 2'd2;
          push.second.status = (~pcrc_upd == f_pcrc) ? ST_OK : ST_BAD_PAYLOAD_CRC;
          push.second.last   = 1'b1;
          idx_nxt   = '0;
          phase_nxt = 1'b0;
          hcrc_nxt  = CrcInit;
          pcrc_nxt  = CrcInit;
          left_nxt  = '0;
        end
      end else if (idx_r < 5'(HdrCrcSpan)) begin
        hcrc_nxt = crc_byte(hcrc_r, in_byte);
        idx_nxt  = idx_r + 5'd1;
      end else if (idx_r != 5'(HdrBytes - 1)) begin
        // gather the stored header CRC, little-endian
        scrc_nxt[{idx_r[1:0], 3'b000} +: 8] = in_byte;
        idx_nxt = idx_r + 5'd1;
      end else begin
        scrc_nxt = hdr_crc_word;
        if (st != ST_OK) begin
          push.count        = 2'd1;
          push.first.status = st;
          push.first.last   = 1'b1;
          idx_nxt   = '0;
          phase_nxt = 1'b0;
          hcrc_nxt  = CrcInit;
          pcrc_nxt  = CrcInit;
          left_nxt  = '0;
        end else begin
          push.first                = blank_res(KIND_HEADER);
          push.first.msg_type       = f_type;
          push.first.flag_bits      = f_flags;
          push.first.reserved_bits  = f_rsvd;
          push.first.correlation_id = {f_corr_hi, f_corr_lo};
          push.first.payload_len    = f_len;
          if (f_len == 32'd0) begin
            push.count         = 2'd2;
            push.second.status = (f_pcrc == 32'd0) ? ST_OK : ST_BAD_PAYLOAD_CRC;
            push.second.last   = 1'b1;
            idx_nxt   = '0;
            phase_nxt = 1'b0;
            hcrc_nxt  = CrcInit;
            pcrc_nxt  = CrcInit;
            left_nxt  = '0;
          end else begin
            push.count      = 2'd1;
            push.first.last = 1'b1;
            idx_nxt   = '0;
            phase_nxt = 1'b1;
            left_nxt  = f_len;
            pcrc_nxt  = CrcInit;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (hdr_wr) begin
      hdr_r[idx_r] <= in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= '0;
      phase_r <= 1'b0;
      hcrc_r  <= CrcInit;
      pcrc_r  <= CrcInit;
      scrc_r  <= '0;
      left_r  <= '0;
    end else begin
      idx_r   <= idx_nxt;
      phase_r <= phase_nxt;
      hcrc_r  <= hcrc_nxt;
      pcrc_r  <= pcrc_nxt;
      scrc_r  <= scrc_nxt;
      left_r  <= left_nxt;
    end
  end

endmodule

// ----- sv/crcdf_out_fifo.sv -----
module crcdf_out_fifo
  import crcdf_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  push_t push,
  input  logic  pop,
  output logic  room2,
  output logic  not_empty,
  output res_t  head
);

  localparam int unsigned PtrW = $clog2(FifoDepth);

  res_t            mem_r [FifoDepth];
  logic [PtrW-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [PtrW:0]   cnt_r, cnt_nxt;
  logic [PtrW-1:0] wp_plus1;

  assign wp_plus1  = wp_r + 1'b1;
  assign room2     = cnt_r <= (PtrW+1)'(FifoDepth - 2);
  assign not_empty = cnt_r != '0;
  assign head      = mem_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r + PtrW'(push.count);
    rp_nxt  = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (PtrW+1)'(push.count) - (PtrW+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) begin
      mem_r[wp_r] <= push.first;
    end
    if (push.count == 2'd2) begin
      mem_r[wp_plus1] <= push.second;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule
